// ===== sv/ipm_pkg.sv =====
// Shared types, codes and helpers for the IPv4 prefix match table.
// Used by ipm_cell and ipv4_prefix_match_table; depends on nothing.
`default_nettype none

package ipm_pkg;

   localparam int ENTRIES_DEF  = 256;
   localparam int TAG_BITS_DEF = 16;

   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
   localparam logic [5:0]  MAX_LEN  = 6'd32;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_MISS   = 2'd1,
      ST_FULL   = 2'd2,
      ST_FAMILY = 2'd3
   } stat_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_SCAN = 1'b1
   } fsm_type;

   typedef enum logic [1:0] {
      CSR_GROUP_MODE = 2'd0
   } csr_addr_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] address;
      logic [5:0]  prefix_len;
      logic [15:0] group_tag;
      logic        is_ipv4;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  matched_len;
      logic [15:0] tag_out;
   } rsp_type;

   typedef struct packed {
      logic       active;
      logic       best_valid;
      logic       exact_found;
      logic       free_found;
      logic [5:0] best_len;
   } scan_type;

   typedef struct packed {
      logic set_new;
      logic set_tag;
      logic kill;
      logic clear_all;
   } cmd_type;

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      return ~(ALL_ONES >> len);
   endfunction

endpackage

`default_nettype wire

// ===== sv/ipm_cell.sv =====
// One table slot of the prefix chain: holds a prefix, length and tag, folds
// its compare into the scan token passing through. Depends on ipm_pkg.
`default_nettype none

module ipm_cell import ipm_pkg::*; #(
   parameter int IDX_W      = 8,
   parameter int TAG_BITS   = TAG_BITS_DEF,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [31:0]         q_address,
   input  wire logic [31:0]         q_base,
   input  wire logic [5:0]          q_len,
   input  wire scan_type            scan_in,
   input  wire logic [TAG_BITS-1:0] best_tag_in,
   input  wire logic [IDX_W-1:0]    exact_idx_in,
   input  wire logic [IDX_W-1:0]    free_idx_in,
   output scan_type                 scan_out,
   output logic [TAG_BITS-1:0]      best_tag_out,
   output logic [IDX_W-1:0]         exact_idx_out,
   output logic [IDX_W-1:0]         free_idx_out,
   input  wire cmd_type             cmd,
   input  wire logic [IDX_W-1:0]    cmd_idx,
   input  wire logic [31:0]         cmd_prefix,
   input  wire logic [5:0]          cmd_len,
   input  wire logic [TAG_BITS-1:0] cmd_tag
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic                valid_ff, valid_in;
   logic [31:0]         prefix_ff, prefix_in;
   logic [5:0]          len_ff, len_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   scan_type            scan_ff, scan_in_nxt;
   logic [TAG_BITS-1:0] best_tag_ff, best_tag_in_nxt;
   logic [IDX_W-1:0]    exact_idx_ff, exact_idx_in_nxt;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in_nxt;

   logic match, exact, take_best, take_exact, take_free, hit_me;

   always_comb begin
      match      = valid_ff && ((q_address & len_mask(len_ff)) == prefix_ff);
      exact      = valid_ff && (len_ff == q_len) && (prefix_ff == q_base);
      take_best  = match && (!scan_in.best_valid || (len_ff > scan_in.best_len));
      take_exact = exact && !scan_in.exact_found;
      take_free  = !valid_ff && !scan_in.free_found;

      scan_in_nxt.active      = scan_in.active;
      scan_in_nxt.best_valid  = scan_in.best_valid | match;
      scan_in_nxt.exact_found = scan_in.exact_found | exact;
      scan_in_nxt.free_found  = scan_in.free_found | !valid_ff;
      scan_in_nxt.best_len    = take_best ? len_ff : scan_in.best_len;
      best_tag_in_nxt         = take_best ? tag_ff : best_tag_in;
      exact_idx_in_nxt        = take_exact ? MY_IDX : exact_idx_in;
      free_idx_in_nxt         = take_free ? MY_IDX : free_idx_in;
   end

   always_comb begin
      hit_me    = (cmd_idx == MY_IDX);
      valid_in  = valid_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      tag_in    = tag_ff;
      if (cmd.clear_all) begin
         valid_in = 1'b0;
      end else if (cmd.set_new && hit_me) begin
         valid_in = 1'b1;
      end else if (cmd.kill && hit_me) begin
         valid_in = 1'b0;
      end
      if (cmd.set_new && hit_me) begin
         prefix_in = cmd_prefix;
         len_in    = cmd_len;
      end
      if ((cmd.set_new || cmd.set_tag) && hit_me) begin
         tag_in = cmd_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         scan_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         scan_ff  <= scan_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff    <= prefix_in;
      len_ff       <= len_in;
      tag_ff       <= tag_in;
      best_tag_ff  <= best_tag_in_nxt;
      exact_idx_ff <= exact_idx_in_nxt;
      free_idx_ff  <= free_idx_in_nxt;
   end

   assign scan_out      = scan_ff;
   assign best_tag_out  = best_tag_ff;
   assign exact_idx_out = exact_idx_ff;
   assign free_idx_out  = free_idx_ff;

endmodule

`default_nettype wire

// ===== sv/ipv4_prefix_match_table.sv =====
// A request passes launch_ff, each slot's scan register and rsp_valid_ff to
// the result strobe; no new request is taken until its scan ends. A token
// walks the cell chain one slot per cycle; the tail commits any table update.
// Reset (synchronous): clears all slot valid bits, group_mode and control.
// Results are strobed for one cycle; the receiver cannot stall them.
// Top level: command port, APB register port and the chain of ipm_cell slots.
`default_nettype none

module ipv4_prefix_match_table import ipm_pkg::*; #(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int IDX_W = $clog2(ENTRIES);

   fsm_type             state_ff, state_in;
   req_type             q_ff;
   logic [5:0]          q_len_ff, q_len_in;
   logic [31:0]         q_base_ff, q_base_in;
   logic                launch_ff, launch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                group_mode_ff, group_mode_in;
   logic                accept;

   scan_type            scan_w      [0:ENTRIES];
   logic [TAG_BITS-1:0] best_tag_w  [0:ENTRIES];
   logic [IDX_W-1:0]    exact_idx_w [0:ENTRIES];
   logic [IDX_W-1:0]    free_idx_w  [0:ENTRIES];

   cmd_type             cmd;
   logic [IDX_W-1:0]    cmd_idx;
   logic [TAG_BITS-1:0] cmd_tag;
   logic [31:0]         tag_wide_in, tag_wide_out;
   scan_type            tail;

   // register port
   assign pready = 1'b1;

   always_comb begin
      group_mode_in = group_mode_ff;
      if (psel && penable && pwrite && (paddr == CSR_GROUP_MODE)) begin
         group_mode_in = pwdata[0];
      end
      prdata = '0;
      if (paddr == CSR_GROUP_MODE) begin
         prdata = {31'd0, group_mode_ff};
      end
   end

   // command intake
   assign busy   = (state_ff != FSM_IDLE);
   assign accept = start && !busy;

   always_comb begin
      q_len_in  = (req_payload.prefix_len > MAX_LEN) ? MAX_LEN : req_payload.prefix_len;
      q_base_in = req_payload.address & len_mask(q_len_in);
   end

   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in  = FSM_SCAN;
               launch_in = 1'b1;
            end
         end
         FSM_SCAN: begin
            if (tail.active) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // chain of slots
   assign scan_w[0]      = '{active: launch_ff, best_valid: 1'b0, exact_found: 1'b0,
                             free_found: 1'b0, best_len: 6'd0};
   assign best_tag_w[0]  = '0;
   assign exact_idx_w[0] = '0;
   assign free_idx_w[0]  = '0;
   assign tail           = scan_w[ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ipm_cell #(
         .IDX_W      (IDX_W),
         .TAG_BITS   (TAG_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .q_address     (q_ff.address),
         .q_base        (q_base_ff),
         .q_len         (q_len_ff),
         .scan_in       (scan_w[i]),
         .best_tag_in   (best_tag_w[i]),
         .exact_idx_in  (exact_idx_w[i]),
         .free_idx_in   (free_idx_w[i]),
         .scan_out      (scan_w[i+1]),
         .best_tag_out  (best_tag_w[i+1]),
         .exact_idx_out (exact_idx_w[i+1]),
         .free_idx_out  (free_idx_w[i+1]),
         .cmd           (cmd),
         .cmd_idx       (cmd_idx),
         .cmd_prefix    (q_base_ff),
         .cmd_len       (q_len_ff),
         .cmd_tag       (cmd_tag)
      );
   end

   // tail: decide result and table update
   always_comb begin
      tag_wide_in  = 32'(q_ff.group_tag);
      cmd_tag      = group_mode_ff ? tag_wide_in[TAG_BITS-1:0] : '0;
      tag_wide_out = 32'(best_tag_w[ENTRIES]);
      cmd          = '0;
      cmd_idx      = '0;
      rsp_in       = '{status: ST_OK, matched_len: 6'd0, tag_out: 16'd0};
      case (q_ff.opcode)
         OP_LOOKUP: begin
            if (q_ff.is_ipv4 && tail.best_valid) begin
               rsp_in.matched_len = tail.best_len;
               rsp_in.tag_out     = group_mode_ff ? tag_wide_out[15:0] : 16'd0;
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         OP_INSERT: begin
            if (!q_ff.is_ipv4) begin
               rsp_in.status = ST_FAMILY;
            end else if (tail.exact_found) begin
               cmd.set_tag = tail.active;
               cmd_idx     = exact_idx_w[ENTRIES];
            end else if (tail.free_found) begin
               cmd.set_new = tail.active;
               cmd_idx     = free_idx_w[ENTRIES];
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         OP_DELETE: begin
            if (q_ff.is_ipv4 && tail.exact_found) begin
               cmd.kill = tail.active;
               cmd_idx  = exact_idx_w[ENTRIES];
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         OP_CLEAR: begin
            cmd.clear_all = tail.active;
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
      rsp_valid_in = tail.active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         launch_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         group_mode_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= launch_in;
         rsp_valid_ff  <= rsp_valid_in;
         group_mode_ff <= group_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff      <= req_payload;
         q_len_ff  <= q_len_in;
         q_base_ff <= q_base_in;
      end
      if (tail.active) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == FSM_SCAN))
      else $error("scan token reached tail outside a scan");

   a_rsp_after_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(tail.active))
      else $error("result strobe without a finished scan");

   a_accept_launches: assert property (@(posedge clock) disable iff (reset)
      accept |=> (launch_ff && busy))
      else $error("accepted transfer did not launch a scan");

   a_new_needs_free: assert property (@(posedge clock) disable iff (reset)
      cmd.set_new |-> (tail.free_found && !tail.exact_found && q_ff.is_ipv4))
      else $error("new slot written without a free slot or with a duplicate");

   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.set_new, cmd.set_tag, cmd.kill, cmd.clear_all}))
      else $error("more than one table update at once");
`endif

endmodule

`default_nettype wire
